// File: src/ring_byte_fifo_bulk_defines.svh
// ring_byte_fifo_bulk_defines.svh: assertion macros for the byte ring fifo
// depends on clk and rst_n in the module that uses them
`ifndef RING_BYTE_FIFO_BULK_DEFINES_SVH
`define RING_BYTE_FIFO_BULK_DEFINES_SVH

// same-cycle implication, off during reset
`define RBF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbf: same-cycle check failed");

// next-cycle implication, off during reset
`define RBF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbf: next-cycle check failed");

`endif

// File: src/rbf_pkg.sv
// rbf_pkg: shared types and constants of the byte ring fifo
// no dependencies
`default_nettype none

package rbf_pkg;

  localparam int BYTE_W     = 8;
  localparam int DATA_BYTES = 8;
  localparam int DATA_W     = BYTE_W * DATA_BYTES;
  localparam int CNT_W      = 4;
  localparam int SIZE_W     = 9;
  localparam int FILL_W     = 8;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

endpackage

`default_nettype wire

// File: src/rbf_bank.sv
// rbf_bank: one byte lane of the ring store, one write and one registered read port
// depends on rbf_pkg
`default_nettype none

module rbf_bank
  import rbf_pkg::*;
#(
  parameter int ROWS = 32,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ROW_W-1:0]  waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ROW_W-1:0]  raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/ring_byte_fifo_bulk.sv
// ring_byte_fifo_bulk: a byte fifo on a banked circular store, write / read / clear per request
// depends on rbf_pkg, rbf_bank and ring_byte_fifo_bulk_defines.svh
//
// usage:
//   in channel: in_tuser carries the opcode (write, read, clear), in_tdata the
//   write bytes and the requested length. out channel: one result per request
//   with the counts, the read bytes and the fill status after the request.
//   cfg_we/cfg_wdata set the ring size (clamped to 2..min(DEPTH,256)) and
//   empty the fifo; write it only while no request is in flight.
//   a request passes through three stages: input register, store access with
//   pointer update, result register. one request is taken every cycle as long
//   as the result side keeps up; the store is LANES byte banks, each read once
//   and written at most once per request.
//   reset empties the fifo, sets the ring size to its maximum and drops any
//   request in flight. the store contents are not cleared.
//   when out_tready is low the result register holds, the stages behind it
//   fill up and in_tready falls once all three are occupied.
`default_nettype none
`include "ring_byte_fifo_bulk_defines.svh"

module ring_byte_fifo_bulk
  import rbf_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int LANES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // cfg: ring_size
  input  wire logic                  cfg_we,
  input  wire logic [SIZE_W-1:0]     cfg_wdata,
  // in_tdata: write_data[63:0], length[67:64], zero pad
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0]
  input  wire logic [OP_W-1:0]       in_tuser,
  // out_tdata: accepted_count[3:0], read_data[67:4], read_count[71:68],
  //            used_count[79:72], free_count[87:80], is_full[88], is_empty[89], zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int TOP_SIZE = (DEPTH < 256) ? DEPTH : 256;
  localparam int ROWS     = (TOP_SIZE + LANES - 1) / LANES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SUM_W    = $clog2(2 * LANES) + 1;

  // handshake and stage control
  logic adv0, adv1, adv2, do_step;

  // input register
  logic              s0_v_r;
  op_t               s0_op_r;
  logic [DATA_W-1:0] s0_wdata_r;
  logic [CNT_W-1:0]  s0_len_r;

  // fifo state
  logic [SIZE_W-1:0] s_r;
  logic [FILL_W-1:0] used_r, used_nxt;
  logic [ROW_W-1:0]  wr_row_r, rd_row_r, wr_row_nxt, rd_row_nxt, wr_row_inc, rd_row_inc;
  logic [LANE_W-1:0] wr_lane_r, rd_lane_r, wr_lane_nxt, rd_lane_nxt;
  logic [SIZE_W-1:0] cfg_size;

  // step logic
  logic [CNT_W-1:0]  len_sat, acc, got, acc_eff, got_eff;
  logic [SIZE_W-1:0] room, lim_nxt;
  logic [SUM_W-1:0]  wr_sum, rd_sum;
  logic              is_wr, is_rd, is_clr;
  logic [FILL_W-1:0] free_nxt;
  logic              full_nxt, empty_nxt;

  // access stage
  logic              s1_v_r;
  logic [CNT_W-1:0]  s1_acc_r, s1_got_r;
  logic [LANE_W-1:0] s1_lane_r;
  logic [FILL_W-1:0] s1_used_r, s1_free_r;
  logic              s1_full_r, s1_empty_r;
  logic [BYTE_W-1:0] bank_q [LANES];
  logic [DATA_W-1:0] rdata_nxt;

  // result register
  logic              out_v_r;
  logic [CNT_W-1:0]  out_acc_r, out_got_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [FILL_W-1:0] out_used_r, out_free_r;
  logic              out_full_r, out_empty_r;

  assign adv2      = !out_v_r || out_tready;
  assign adv1      = !s1_v_r || adv2;
  assign adv0      = !s0_v_r || adv1;
  assign do_step   = s0_v_r && adv1;
  assign in_tready = adv0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv0) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_tvalid) begin
      s0_op_r    <= op_t'(in_tuser);
      s0_wdata_r <= in_tdata[DATA_W-1:0];
      s0_len_r   <= in_tdata[DATA_W +: CNT_W];
    end
  end

  // step logic
  always_comb begin
    if (cfg_wdata < SIZE_W'(2)) begin
      cfg_size = SIZE_W'(2);
    end else if (cfg_wdata > SIZE_W'(TOP_SIZE)) begin
      cfg_size = SIZE_W'(TOP_SIZE);
    end else begin
      cfg_size = cfg_wdata;
    end
  end

  assign wr_row_inc = (wr_row_r == ROW_W'(ROWS - 1)) ? '0 : wr_row_r + ROW_W'(1);
  assign rd_row_inc = (rd_row_r == ROW_W'(ROWS - 1)) ? '0 : rd_row_r + ROW_W'(1);

  assign is_wr  = (s0_op_r == OP_WRITE);
  assign is_rd  = (s0_op_r == OP_READ);
  assign is_clr = (s0_op_r == OP_CLEAR);

  always_comb begin
    len_sat = (s0_len_r > CNT_W'(LANES)) ? CNT_W'(LANES) : s0_len_r;
    room    = s_r - SIZE_W'(1) - {1'b0, used_r};
    acc     = ({{(SIZE_W-CNT_W){1'b0}}, len_sat} < room) ? len_sat : room[CNT_W-1:0];
    got     = ({{(FILL_W-CNT_W){1'b0}}, len_sat} < used_r) ? len_sat : used_r[CNT_W-1:0];
    acc_eff = is_wr ? acc : '0;
    got_eff = is_rd ? got : '0;

    wr_sum = SUM_W'(wr_lane_r) + SUM_W'(acc_eff);
    rd_sum = SUM_W'(rd_lane_r) + SUM_W'(got_eff);

    wr_lane_nxt = wr_lane_r;
    wr_row_nxt  = wr_row_r;
    rd_lane_nxt = rd_lane_r;
    rd_row_nxt  = rd_row_r;
    used_nxt    = used_r;

    case (s0_op_r)
      OP_WRITE: begin
        used_nxt = used_r + FILL_W'(acc_eff);
        if (wr_sum >= SUM_W'(LANES)) begin
          wr_lane_nxt = LANE_W'(wr_sum - SUM_W'(LANES));
          wr_row_nxt  = wr_row_inc;
        end else begin
          wr_lane_nxt = LANE_W'(wr_sum);
        end
      end
      OP_READ: begin
        used_nxt = used_r - FILL_W'(got_eff);
        if (rd_sum >= SUM_W'(LANES)) begin
          rd_lane_nxt = LANE_W'(rd_sum - SUM_W'(LANES));
          rd_row_nxt  = rd_row_inc;
        end else begin
          rd_lane_nxt = LANE_W'(rd_sum);
        end
      end
      OP_CLEAR: begin
        used_nxt    = '0;
        rd_lane_nxt = wr_lane_r;
        rd_row_nxt  = wr_row_r;
      end
      default: begin
        used_nxt = used_r;
      end
    endcase

    lim_nxt   = s_r - SIZE_W'(1);
    free_nxt  = FILL_W'(lim_nxt - {1'b0, used_nxt});
    full_nxt  = ({1'b0, used_nxt} == lim_nxt);
    empty_nxt = (used_nxt == '0);
  end

  // fifo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r       <= SIZE_W'(TOP_SIZE);
      used_r    <= '0;
      wr_row_r  <= '0;
      wr_lane_r <= '0;
      rd_row_r  <= '0;
      rd_lane_r <= '0;
    end else if (cfg_we) begin
      s_r       <= cfg_size;
      used_r    <= '0;
      wr_row_r  <= '0;
      wr_lane_r <= '0;
      rd_row_r  <= '0;
      rd_lane_r <= '0;
    end else if (do_step) begin
      used_r    <= used_nxt;
      wr_row_r  <= wr_row_nxt;
      wr_lane_r <= wr_lane_nxt;
      rd_row_r  <= rd_row_nxt;
      rd_lane_r <= rd_lane_nxt;
    end
  end

  // byte banks
  for (genvar k = 0; k < LANES; k++) begin : g_bank
    logic [SUM_W-1:0]  off_sum;
    logic [LANE_W-1:0] off;
    logic              we;
    logic [ROW_W-1:0]  waddr, raddr;
    logic [BYTE_W-1:0] wdata;

    assign off_sum = SUM_W'(k) + SUM_W'(LANES) - SUM_W'(wr_lane_r);
    assign off     = (off_sum >= SUM_W'(LANES)) ? LANE_W'(off_sum - SUM_W'(LANES))
                                                : LANE_W'(off_sum);
    assign we      = do_step && is_wr && (SUM_W'(off) < SUM_W'(acc));
    assign waddr   = (LANE_W'(k) >= wr_lane_r) ? wr_row_r : wr_row_inc;
    assign raddr   = (LANE_W'(k) >= rd_lane_r) ? rd_row_r : rd_row_inc;
    assign wdata   = s0_wdata_r[{off, 3'b000} +: BYTE_W];

    rbf_bank #(
      .ROWS(ROWS)
    ) u_bank (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (do_step),
      .raddr(raddr),
      .rdata(bank_q[k])
    );
  end

  // access stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      s1_acc_r   <= acc_eff;
      s1_got_r   <= got_eff;
      s1_lane_r  <= rd_lane_r;
      s1_used_r  <= used_nxt;
      s1_free_r  <= free_nxt;
      s1_full_r  <= full_nxt;
      s1_empty_r <= empty_nxt;
    end
  end

  // rotate bank outputs back into request order
  always_comb begin
    logic [SUM_W-1:0]  sidx;
    logic [LANE_W-1:0] idx;
    rdata_nxt = '0;
    sidx      = '0;
    idx       = '0;
    for (int j = 0; j < DATA_BYTES; j++) begin
      if (j < LANES) begin
        sidx = SUM_W'(s1_lane_r) + SUM_W'(j);
        idx  = (sidx >= SUM_W'(LANES)) ? LANE_W'(sidx - SUM_W'(LANES)) : LANE_W'(sidx);
        if (CNT_W'(j) < s1_got_r) begin
          rdata_nxt[j*BYTE_W +: BYTE_W] = bank_q[idx];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv2) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      out_acc_r   <= s1_acc_r;
      out_got_r   <= s1_got_r;
      out_rdata_r <= rdata_nxt;
      out_used_r  <= s1_used_r;
      out_free_r  <= s1_free_r;
      out_full_r  <= s1_full_r;
      out_empty_r <= s1_empty_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_empty_r, out_full_r, out_free_r, out_used_r,
                       out_got_r, out_rdata_r, out_acc_r};

  `RBF_ASSERT_IMPL(a_used_cap, 1'b1, ({1'b0, used_r} < s_r))
  `RBF_ASSERT_IMPL(a_one_dir, s1_v_r, ((s1_acc_r == '0) || (s1_got_r == '0)))
  `RBF_ASSERT_NEXT(a_clear_empties, do_step && is_clr, (used_r == '0))
  `RBF_ASSERT_NEXT(a_state_idle, !do_step && !cfg_we, $stable(used_r))
  `RBF_ASSERT_NEXT(a_lane_idle, !do_step && !cfg_we, ($stable(wr_lane_r) && $stable(rd_lane_r)))

endmodule

`default_nettype wire
